### hw/rtl/aces_fitted_tone_map_defines.svh
// assertion macros for the aces fitted tone map block
// expects clk and rst_n in the scope of each use
`ifndef ACES_FITTED_TONE_MAP_DEFINES_SVH
`define ACES_FITTED_TONE_MAP_DEFINES_SVH

// same-cycle implication
`define AFT_ASSERT_NOW(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("aft assertion failed");

// next-cycle implication
`define AFT_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("aft assertion failed");

`endif

### hw/rtl/aft_pkg.sv
// constants and helpers for the aces fitted tone map
// no dependencies
package aft_pkg;

    localparam longint DecScale = 64'sd1000000000;
    localparam longint DecHalf  = 64'sd500000000;

    localparam longint InMatDec [9] = '{
        64'sd597190000, 64'sd354580000, 64'sd48230000,
        64'sd76000000,  64'sd908340000, 64'sd15660000,
        64'sd28400000,  64'sd133830000, 64'sd837770000
    };

    localparam longint OutMatDec [9] = '{
        64'sd1604750000, -64'sd531080000,  -64'sd73670000,
        -64'sd102080000, 64'sd1108130000,  -64'sd6050000,
        -64'sd3270000,   -64'sd72760000,   64'sd1076020000
    };

    localparam longint FitADec = 64'sd24578600;
    localparam longint FitBDec = 64'sd90537;
    localparam longint FitCDec = 64'sd983729000;
    localparam longint FitDDec = 64'sd432951000;
    localparam longint FitEDec = 64'sd238081000;

    // round a 1e9-scaled decimal to f fraction bits, half away from zero
    function automatic longint quant(longint dec, int f);
        longint mag;
        longint q;
        mag = (dec < 0) ? -dec : dec;
        q   = ((mag <<< f) + DecHalf) / DecScale;
        return (dec < 0) ? -q : q;
    endfunction

endpackage

### hw/rtl/aces_fitted_tone_map.sv
// aces fitted tone map: throughput one pixel per clock while out_ready is high;
// back-pressure from out_ready stalls the pipeline
// the fit division is a restoring divider, one quotient bit per stage over
// FRACTION_BITS+2 stages; stages stall individually so bubbles are absorbed
// rst_n clears all stage valid bits asynchronously; data registers are not reset
// depends on aft_pkg and aces_fitted_tone_map_defines.svh
`include "aces_fitted_tone_map_defines.svh"

module aces_fitted_tone_map #(
    parameter int FRACTION_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [23:0] red_in,
    input  logic [23:0] green_in,
    input  logic [23:0] blue_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [16:0] red_out,
    output logic [16:0] green_out,
    output logic [16:0] blue_out
);

    localparam int F    = FRACTION_BITS;
    localparam int WW   = F + 9;
    localparam int WAW  = 2 * WW + 1;
    localparam int NW   = F + 18;
    localparam int Q    = F + 2;
    localparam int QW   = Q + 1;
    localparam int CIW  = F;
    localparam int PIW  = CIW + 24;
    localparam int SIW  = PIW + 2;
    localparam int KCWW = CIW + WW;
    localparam int COW  = F + 2;
    localparam int POW  = QW + COW;
    localparam int SOW  = POW + 2;
    localparam int NS   = Q + 10;
    localparam int ST_P6  = 5;
    localparam int ST_D0  = 6;
    localparam int ST_OUT = NS - 1;

    function automatic logic [CIW-1:0] in_c(int i);
        return CIW'(aft_pkg::quant(aft_pkg::InMatDec[i], F));
    endfunction

    function automatic logic signed [COW-1:0] out_c(int i);
        return signed'(COW'(aft_pkg::quant(aft_pkg::OutMatDec[i], F)));
    endfunction

    localparam logic [CIW-1:0] KIN [9] = '{
        in_c(0), in_c(1), in_c(2), in_c(3), in_c(4), in_c(5), in_c(6), in_c(7), in_c(8)
    };
    localparam logic signed [COW-1:0] KOUT [9] = '{
        out_c(0), out_c(1), out_c(2), out_c(3), out_c(4), out_c(5), out_c(6), out_c(7),
        out_c(8)
    };
    localparam logic [F-1:0]   KA = F'(aft_pkg::quant(aft_pkg::FitADec, F));
    localparam logic [F-1:0]   KB = F'(aft_pkg::quant(aft_pkg::FitBDec, F));
    localparam logic [CIW-1:0] KC = CIW'(aft_pkg::quant(aft_pkg::FitCDec, F));
    localparam logic [F-1:0]   KD = F'(aft_pkg::quant(aft_pkg::FitDDec, F));
    localparam logic [F-1:0]   KE = F'(aft_pkg::quant(aft_pkg::FitEDec, F));
    localparam logic signed [SOW-1:0] ONE = SOW'(64'sd1 <<< (2 * F));
    localparam logic signed [SOW-1:0] RND = SOW'(64'sd1 <<< (2 * F - 17));

    // stage control
    logic [NS-1:0] v_reg;
    logic [NS-1:0] v_next;
    logic [NS-1:0] en;

    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || out_ready;
        for (int i = NS - 2; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
        v_next[0] = en[0] ? in_valid : v_reg[0];
        for (int i = 1; i < NS; i++)
        begin
            v_next[i] = en[i] ? v_reg[i-1] : v_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[ST_OUT];

    // datapath registers
    logic [PIW-1:0]         prod1_reg [3][3];
    logic [PIW-1:0]         prod1_next [3][3];
    logic [WW-1:0]          w_reg [3];
    logic [WW-1:0]          w_next [3];
    logic [WAW-1:0]         wa_reg [3];
    logic [WAW-1:0]         wa_next [3];
    logic [KCWW-1:0]        kcw_reg [3];
    logic [KCWW-1:0]        kcw_next [3];
    logic [WW-1:0]          w3_reg [3];
    logic signed [NW:0]     num_reg [3];
    logic signed [NW:0]     num_next [3];
    logic [WW:0]            t_reg [3];
    logic [WW:0]            t_next [3];
    logic [WW-1:0]          w4_reg [3];
    logic [WAW-1:0]         p_reg [3];
    logic [WAW-1:0]         p_next [3];
    logic signed [NW:0]     num5_reg [3];
    logic [NW-1:0]          den_reg [3];
    logic [NW-1:0]          den_next [3];
    logic [NW-1:0]          mag_reg [3];
    logic [NW-1:0]          mag_next [3];
    logic                   neg6_reg [3];
    logic [NW-1:0]          rem_reg [Q][3];
    logic [NW-1:0]          rem_next [Q][3];
    logic [Q-1:0]           quo_reg [Q][3];
    logic [Q-1:0]           quo_next [Q][3];
    logic [NW-1:0]          dd_reg [Q][3];
    logic [1:0]             ml_reg [Q][3];
    logic                   dn_reg [Q][3];
    logic signed [QW-1:0]   q_reg [3];
    logic signed [QW-1:0]   q_next [3];
    logic signed [POW-1:0]  prod2_reg [3][3];
    logic signed [POW-1:0]  prod2_next [3][3];
    logic signed [SOW-1:0]  sum_reg [3];
    logic signed [SOW-1:0]  sum_next [3];
    logic [16:0]            res_reg [3];
    logic [16:0]            res_next [3];

    logic [23:0] px [3];
    assign px[0] = red_in;
    assign px[1] = green_in;
    assign px[2] = blue_in;

    // input matrix, rational fit front end
    always_comb
    begin
        logic [SIW-1:0] s1;
        logic [WW:0]    wpa;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                prod1_next[r][c] = PIW'(KIN[r*3+c]) * PIW'(px[c]);
            end
            s1 = SIW'(prod1_reg[r][0]) + SIW'(prod1_reg[r][1]) + SIW'(prod1_reg[r][2]);
            w_next[r] = WW'((s1 + SIW'(32768)) >> 16);
            wpa = (WW+1)'(w_reg[r]) + (WW+1)'(KA);
            wa_next[r]  = WAW'(w_reg[r]) * WAW'(wpa);
            kcw_next[r] = KCWW'(KC) * KCWW'(w_reg[r]);
            num_next[r] = signed'((NW+1)'(wa_reg[r] >> F)) - signed'((NW+1)'(KB));
            t_next[r]   = (WW+1)'(kcw_reg[r] >> F) + (WW+1)'(KD);
            p_next[r]   = WAW'(w4_reg[r]) * WAW'(t_reg[r]);
            den_next[r] = NW'(p_reg[r] >> F) + NW'(KE);
            mag_next[r] = (num5_reg[r] < 0) ? NW'(-num5_reg[r]) : NW'(num5_reg[r]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            prod1_reg <= prod1_next;
        end
        if (en[1])
        begin
            w_reg <= w_next;
        end
        if (en[2])
        begin
            wa_reg  <= wa_next;
            kcw_reg <= kcw_next;
            w3_reg  <= w_reg;
        end
        if (en[3])
        begin
            num_reg <= num_next;
            t_reg   <= t_next;
            w4_reg  <= w3_reg;
        end
        if (en[4])
        begin
            p_reg    <= p_next;
            num5_reg <= num_reg;
        end
        if (en[ST_P6])
        begin
            den_reg <= den_next;
            mag_reg <= mag_next;
            for (int r = 0; r < 3; r++)
            begin
                neg6_reg[r] <= num5_reg[r] < 0;
            end
        end
    end

    // restoring divider, one quotient bit per stage
    for (genvar k = 0; k < Q; k++) begin : g_div
        localparam int KP = (k == 0) ? 0 : k - 1;

        always_comb
        begin
            logic [NW-1:0] rin;
            logic [NW-1:0] dv;
            logic [Q-1:0]  qin;
            logic          nb;
            logic [NW:0]   sh;
            for (int r = 0; r < 3; r++)
            begin
                if (k == 0)
                begin
                    rin = mag_reg[r] >> 2;
                    dv  = den_reg[r];
                    qin = '0;
                    nb  = mag_reg[r][1];
                end
                else
                begin
                    rin = rem_reg[KP][r];
                    dv  = dd_reg[KP][r];
                    qin = quo_reg[KP][r];
                    nb  = (k == 1) ? ml_reg[KP][r][0] : 1'b0;
                end
                sh = {rin, nb};
                if (sh >= {1'b0, dv})
                begin
                    rem_next[k][r] = NW'(sh - {1'b0, dv});
                    quo_next[k][r] = {qin[Q-2:0], 1'b1};
                end
                else
                begin
                    rem_next[k][r] = NW'(sh);
                    quo_next[k][r] = {qin[Q-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[ST_D0+k])
            begin
                rem_reg[k] <= rem_next[k];
                quo_reg[k] <= quo_next[k];
                for (int r = 0; r < 3; r++)
                begin
                    if (k == 0)
                    begin
                        dd_reg[k][r] <= den_reg[r];
                        ml_reg[k][r] <= mag_reg[r][1:0];
                        dn_reg[k][r] <= neg6_reg[r];
                    end
                    else
                    begin
                        dd_reg[k][r] <= dd_reg[KP][r];
                        ml_reg[k][r] <= ml_reg[KP][r];
                        dn_reg[k][r] <= dn_reg[KP][r];
                    end
                end
            end
        end
    end

    // sign, output matrix, clamp and round
    always_comb
    begin
        logic signed [QW-1:0] qm;
        for (int r = 0; r < 3; r++)
        begin
            qm = signed'(QW'(quo_reg[Q-1][r]));
            q_next[r] = dn_reg[Q-1][r] ? -qm : qm;
            for (int c = 0; c < 3; c++)
            begin
                prod2_next[r][c] = POW'(KOUT[r*3+c]) * POW'(q_reg[c]);
            end
            sum_next[r] = SOW'(prod2_reg[r][0]) + SOW'(prod2_reg[r][1])
                        + SOW'(prod2_reg[r][2]);
            if (sum_reg[r] <= 0)
            begin
                res_next[r] = '0;
            end
            else if (sum_reg[r] >= ONE)
            begin
                res_next[r] = 17'd65536;
            end
            else
            begin
                res_next[r] = 17'((sum_reg[r] + RND) >>> (2 * F - 16));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_D0+Q])
        begin
            q_reg <= q_next;
        end
        if (en[ST_D0+Q+1])
        begin
            prod2_reg <= prod2_next;
        end
        if (en[ST_D0+Q+2])
        begin
            sum_reg <= sum_next;
        end
        if (en[ST_OUT])
        begin
            res_reg <= res_next;
        end
    end

    assign red_out   = res_reg[0];
    assign green_out = res_reg[1];
    assign blue_out  = res_reg[2];

    logic out_in_range;
    logic den_nonzero;

    assign out_in_range = (red_out <= 17'd65536) && (green_out <= 17'd65536)
                       && (blue_out <= 17'd65536);
    assign den_nonzero  = (dd_reg[0][0] != '0) && (dd_reg[0][1] != '0)
                       && (dd_reg[0][2] != '0);

    `AFT_ASSERT_NOW(a_out_clamped, out_valid, out_in_range)
    `AFT_ASSERT_NOW(a_den_nonzero, v_reg[ST_D0], den_nonzero)
    `AFT_ASSERT_NEXT(a_stall_holds, v_reg[ST_D0+Q-1] && !en[ST_D0+Q-1], v_reg[ST_D0+Q-1])

endmodule
